@@ hdl/assert_macros.svh @@
// Assertion macros used by the framer controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/gcpf_pkg.sv @@
// Package: types and constants of the command packet framer
`timescale 1ns / 1ps
package gcpf_pkg;
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_VRAM_WR = 3'd1;
   localparam logic [2:0] KIND_VRAM_RD = 3'd2;
   localparam logic [2:0] KIND_PACKET = 3'd3;
   localparam logic [2:0] KIND_SETTING = 3'd4;
   localparam logic [2:0] KIND_IRQ = 3'd5;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_TO_VRAM = 2'd1;
   localparam logic [1:0] MODE_FROM_VRAM = 2'd2;

   localparam logic [7:0] OP_IRQ = 8'h1f;
   localparam logic [7:0] OP_TO_VRAM = 8'ha0;
   localparam logic [7:0] OP_FROM_VRAM = 8'hc0;
   localparam logic [7:0] OP_SET_FIRST = 8'he1;
   localparam logic [7:0] OP_SET_LAST = 8'he6;
   localparam logic [31:0] POLY_END_A = 32'h5555_5555;
   localparam logic [31:0] POLY_END_B = 32'h5000_5000;
   localparam logic [15:0] MASK_BIT = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EMIT,
      ST_HALF0,
      ST_HALF1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture input item
      logic decode;    // run normal-mode decode on held word
      logic emit;      // packet word taken: step the emit index
      logic emit_done; // finish packet: texture, transfer, polyline
      logic half;      // transfer halfword taken: step position
      logic half_hi;   // which halfword of the word
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic [1:0] mode;
      logic complete;   // held word completes a packet
      logic single;     // held word gives one immediate result
      logic emit_last;  // emit index is at final word
      logic xfer_end;   // next step ends the transfer
   } dp_status_type;

   function automatic logic [3:0] packet_words(input logic [7:0] op);
      logic [7:0] g;
      logic [3:0] n;
      g = op & 8'hfc;
      n = 4'd0;
      if (op == 8'h02) n = 4'd3;
      else if (g == 8'h20) n = 4'd4;
      else if (g == 8'h24) n = 4'd7;
      else if (g == 8'h28) n = 4'd5;
      else if (g == 8'h2c) n = 4'd9;
      else if (g == 8'h30) n = 4'd6;
      else if (g == 8'h34) n = 4'd9;
      else if (g == 8'h38) n = 4'd8;
      else if (g == 8'h3c) n = 4'd12;
      else if (g == 8'h40) n = 4'd3;
      else if (op == 8'h48 || op == 8'h4a || op == 8'h4c || op == 8'h4e) n = 4'd3;
      else if (g == 8'h50) n = 4'd4;
      else if (op == 8'h58 || op == 8'h5a || op == 8'h5c || op == 8'h5e) n = 4'd4;
      else if (g == 8'h60) n = 4'd3;
      else if (g == 8'h64) n = 4'd4;
      else if (g == 8'h68) n = 4'd2;
      else if (g == 8'h6c) n = 4'd3;
      else if (g == 8'h70) n = 4'd2;
      else if (g == 8'h74) n = 4'd3;
      else if (g == 8'h78) n = 4'd2;
      else if (g == 8'h7c) n = 4'd3;
      else if (op == 8'h80) n = 4'd4;
      else if (op == OP_TO_VRAM || op == OP_FROM_VRAM) n = 4'd3;
      return n;
   endfunction

   function automatic logic is_polyline(input logic [7:0] op);
      return (op & 8'he9) == 8'h48;
   endfunction
endpackage

@@ hdl/gcpf_ctrl.sv @@
// Controller state machine of the command packet framer
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gcpf_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   output logic out_last,
   output gcpf_pkg::dp_cmd_type cmd,
   input  gcpf_pkg::dp_status_type sts
);
   gcpf_pkg::state_type state_ff, state_in;
   logic fire;

   assign fire = out_valid & out_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcpf_pkg::ST_IDLE: if (in_valid) state_in = gcpf_pkg::ST_DECODE;
         gcpf_pkg::ST_DECODE: begin
            if (sts.is_read) begin
               state_in = (sts.mode == gcpf_pkg::MODE_FROM_VRAM) ?
                          gcpf_pkg::ST_HALF0 : gcpf_pkg::ST_IDLE;
            end else if (sts.mode == gcpf_pkg::MODE_TO_VRAM) begin
               state_in = gcpf_pkg::ST_HALF0;
            end else if (sts.single) begin
               if (fire) state_in = gcpf_pkg::ST_IDLE;
            end else if (sts.complete) begin
               state_in = gcpf_pkg::ST_EMIT;
            end else begin
               state_in = gcpf_pkg::ST_IDLE;
            end
         end
         gcpf_pkg::ST_EMIT: if (fire && sts.emit_last) state_in = gcpf_pkg::ST_IDLE;
         gcpf_pkg::ST_HALF0: begin
            if (fire) state_in = sts.xfer_end ? gcpf_pkg::ST_IDLE : gcpf_pkg::ST_HALF1;
         end
         gcpf_pkg::ST_HALF1: if (fire) state_in = gcpf_pkg::ST_IDLE;
         default: state_in = gcpf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready = 1'b0;
      out_valid = 1'b0;
      out_last = 1'b0;
      cmd = '0;
      unique case (state_ff)
         gcpf_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         gcpf_pkg::ST_DECODE: begin
            if (!sts.is_read && sts.mode != gcpf_pkg::MODE_TO_VRAM && sts.single) begin
               out_valid = 1'b1;
               out_last = 1'b1;
               cmd.decode = fire;
            end else if (!sts.is_read && sts.mode != gcpf_pkg::MODE_TO_VRAM) begin
               cmd.decode = 1'b1;
            end
         end
         gcpf_pkg::ST_EMIT: begin
            out_valid = 1'b1;
            out_last = sts.emit_last;
            cmd.emit = fire;
            cmd.emit_done = fire & sts.emit_last;
         end
         gcpf_pkg::ST_HALF0: begin
            out_valid = 1'b1;
            out_last = sts.xfer_end;
            cmd.half = fire;
         end
         gcpf_pkg::ST_HALF1: begin
            out_valid = 1'b1;
            out_last = 1'b1;
            cmd.half = fire;
            cmd.half_hi = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gcpf_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, in_ready, state_ff == gcpf_pkg::ST_IDLE, "ready outside idle")
   `ASSERT_NEXT(a_load_decode, clock, reset, cmd.load, state_ff == gcpf_pkg::ST_DECODE, "load did not decode")
   `ASSERT_IMPLIES(a_no_overlap, clock, reset, in_ready, !out_valid, "result with ready")
endmodule

@@ hdl/gcpf_dp.sv @@
// Datapath of the command packet framer: packet store, draw state, transfer stepping
`timescale 1ns / 1ps
module gcpf_dp #(
   parameter int MAX_PACKET_WORDS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic color_depth_24,
   input  logic in_command,
   input  logic [31:0] in_word,
   input  gcpf_pkg::dp_cmd_type cmd,
   output gcpf_pkg::dp_status_type sts,
   output logic [2:0] out_kind,
   output logic [18:0] out_vram_address,
   output logic [15:0] out_vram_data,
   output logic out_skip_if_masked,
   output logic out_read_half_high,
   output logic [7:0] out_packet_opcode,
   output logic [3:0] out_packet_index,
   output logic [31:0] out_payload
);
   localparam int IW = $clog2(MAX_PACKET_WORDS);
   localparam int CW = $clog2(MAX_PACKET_WORDS + 1);

   logic [31:0] store_ff [MAX_PACKET_WORDS];
   logic is_read_ff;
   logic [31:0] word_ff;
   logic [1:0] mode_ff;
   logic [CW-1:0] plen_ff;
   logic [7:0] pcode_ff;
   logic [3:0] elen_ff;
   logic [CW-1:0] eidx_ff;
   logic [9:0] ox_ff;
   logic [8:0] oy_ff;
   logic [10:0] cw_ff;
   logic [9:0] ch_ff;
   logic [10:0] sx_ff;
   logic [9:0] sy_ff;
   logic fmask_ff, cmask_ff, irq_ff;
   logic [13:0] dmode_ff;
   logic [19:0] twin_ff, atl_ff, abr_ff;
   logic [21:0] doff_ff;
   logic [14:0] tpal_ff;

   logic [7:0] op;
   logic [3:0] len;
   logic is_set, is_term;
   logic [CW-1:0] plen_inc;
   logic [10:0] sx_inc;
   logic [9:0] sy_inc;
   logic x_wrap, y_end;
   logic [9:0] ax;
   logic [8:0] ay;
   logic [15:0] mbit;
   logic [31:0] eword;

   assign op = (plen_ff == '0) ? word_ff[31:24] : pcode_ff;
   assign len = gcpf_pkg::packet_words(op);
   assign is_set = (op >= gcpf_pkg::OP_SET_FIRST) && (op <= gcpf_pkg::OP_SET_LAST);
   assign is_term = gcpf_pkg::is_polyline(op) &&
                    (word_ff == gcpf_pkg::POLY_END_A || word_ff == gcpf_pkg::POLY_END_B);
   assign plen_inc = (plen_ff < CW'(MAX_PACKET_WORDS)) ? plen_ff + 1'b1 : plen_ff;

   assign sx_inc = sx_ff + 11'd1;
   assign x_wrap = sx_inc >= cw_ff;
   assign sy_inc = sy_ff + 10'd1;
   assign y_end = x_wrap && (sy_inc >= ch_ff);
   assign ax = ox_ff + sx_ff[9:0];
   assign ay = oy_ff + sy_ff[8:0];
   assign mbit = (fmask_ff && !color_depth_24) ? gcpf_pkg::MASK_BIT : 16'd0;
   assign eword = store_ff[eidx_ff[IW-1:0]];

   assign sts.is_read = is_read_ff;
   assign sts.mode = mode_ff;
   assign sts.single = (op == gcpf_pkg::OP_IRQ) || is_set;
   assign sts.complete = (len != 4'd0) && !is_term && ({1'b0, plen_inc} >= (CW+1)'(len));
   assign sts.emit_last = ({1'b0, eidx_ff} + 1'b1) >= (CW+1)'(elen_ff);
   assign sts.xfer_end = y_end;

   always_comb begin
      out_kind = gcpf_pkg::KIND_NONE;
      out_vram_address = '0;
      out_vram_data = '0;
      out_skip_if_masked = 1'b0;
      out_read_half_high = 1'b0;
      out_packet_opcode = '0;
      out_packet_index = '0;
      out_payload = '0;
      if (mode_ff == gcpf_pkg::MODE_TO_VRAM && !is_read_ff) begin
         out_kind = gcpf_pkg::KIND_VRAM_WR;
         out_vram_address = {ay, ax};
         out_vram_data = (cmd.half_hi ? word_ff[31:16] : word_ff[15:0]) | mbit;
         out_skip_if_masked = cmask_ff;
      end else if (is_read_ff) begin
         out_kind = gcpf_pkg::KIND_VRAM_RD;
         out_vram_address = {ay, ax};
         out_read_half_high = cmd.half_hi | y_end;
      end else if (op == gcpf_pkg::OP_IRQ) begin
         out_kind = gcpf_pkg::KIND_IRQ;
         out_packet_opcode = op;
      end else if (is_set) begin
         out_kind = gcpf_pkg::KIND_SETTING;
         out_packet_opcode = op;
         out_payload = {8'd0, word_ff[23:0]};
      end else begin
         out_kind = gcpf_pkg::KIND_PACKET;
         out_packet_opcode = pcode_ff;
         out_packet_index = 4'(eidx_ff);
         out_payload = eword;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff <= in_command;
         word_ff <= in_word;
      end
      if (cmd.decode && !sts.single && len != 4'd0 && !is_term &&
          plen_ff < CW'(MAX_PACKET_WORDS)) begin
         store_ff[plen_ff[IW-1:0]] <= word_ff;
      end
      if (cmd.emit_done && gcpf_pkg::is_polyline(pcode_ff)) begin
         store_ff[0] <= store_ff[(elen_ff == 4'd3) ? IW'(0) : IW'(2)];
         store_ff[1] <= store_ff[(elen_ff == 4'd3) ? IW'(2) : IW'(3)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gcpf_pkg::MODE_NORMAL;
         plen_ff <= '0;
         pcode_ff <= '0;
         elen_ff <= '0;
         eidx_ff <= '0;
         ox_ff <= '0;
         oy_ff <= '0;
         cw_ff <= 11'd1;
         ch_ff <= 10'd1;
         sx_ff <= '0;
         sy_ff <= '0;
         fmask_ff <= 1'b0;
         cmask_ff <= 1'b0;
         irq_ff <= 1'b0;
         dmode_ff <= '0;
         twin_ff <= '0;
         atl_ff <= '0;
         abr_ff <= '0;
         doff_ff <= '0;
         tpal_ff <= '0;
      end else begin
         if (cmd.decode) begin
            pcode_ff <= op;
            if (op == gcpf_pkg::OP_IRQ) begin
               irq_ff <= 1'b1;
            end else if (is_set) begin
               unique case (op[2:0])
                  3'd1: dmode_ff <= word_ff[13:0];
                  3'd2: twin_ff <= word_ff[19:0];
                  3'd3: atl_ff <= word_ff[19:0];
                  3'd4: abr_ff <= word_ff[19:0];
                  3'd5: doff_ff <= word_ff[21:0];
                  3'd6: begin
                     fmask_ff <= word_ff[0];
                     cmask_ff <= word_ff[1];
                  end
                  default: ;
               endcase
            end else if (len != 4'd0) begin
               if (is_term) plen_ff <= '0;
               else plen_ff <= plen_inc;
               elen_ff <= len;
               eidx_ff <= '0;
            end
         end
         if (cmd.emit) eidx_ff <= eidx_ff + 1'b1;
         if (cmd.emit_done) begin
            // polylines keep last colour and point as the next segment's start
            plen_ff <= gcpf_pkg::is_polyline(pcode_ff) ? CW'(2) : CW'(0);
            if ((pcode_ff & 8'hfc) == 8'h24 || (pcode_ff & 8'hfc) == 8'h2c ||
                (pcode_ff & 8'hfc) == 8'h34 || (pcode_ff & 8'hfc) == 8'h3c ||
                (pcode_ff & 8'he4) == 8'h64) begin
               tpal_ff <= store_ff[2][30:16];
            end
            if ((pcode_ff & 8'hfc) == 8'h24 || (pcode_ff & 8'hfc) == 8'h2c) begin
               dmode_ff <= {dmode_ff[13:12], store_ff[4][27], dmode_ff[10:9],
                            store_ff[4][24:16]};
            end
            if ((pcode_ff & 8'hfc) == 8'h34 || (pcode_ff & 8'hfc) == 8'h3c) begin
               dmode_ff <= {dmode_ff[13:12], store_ff[5][27], dmode_ff[10:9],
                            store_ff[5][24:16]};
            end
            if (pcode_ff == gcpf_pkg::OP_TO_VRAM || pcode_ff == gcpf_pkg::OP_FROM_VRAM) begin
               ox_ff <= store_ff[1][9:0];
               oy_ff <= store_ff[1][24:16];
               cw_ff <= {1'b0, store_ff[2][9:0] - 10'd1} + 11'd1;
               ch_ff <= {1'b0, store_ff[2][24:16] - 9'd1} + 10'd1;
               sx_ff <= '0;
               sy_ff <= '0;
               mode_ff <= (pcode_ff == gcpf_pkg::OP_TO_VRAM) ?
                          gcpf_pkg::MODE_TO_VRAM : gcpf_pkg::MODE_FROM_VRAM;
            end
         end
         if (cmd.half) begin
            if (x_wrap) begin
               sx_ff <= '0;
               if (y_end) begin
                  sy_ff <= '0;
                  mode_ff <= gcpf_pkg::MODE_NORMAL;
               end else begin
                  sy_ff <= sy_inc;
               end
            end else begin
               sx_ff <= sx_inc;
            end
         end
      end
   end
endmodule

@@ hdl/gpu_command_packet_framer_core.sv @@
// Top level: graphics command port with packet framing and VRAM transfers
// Timing: settings and interrupts present their result in the cycle after the item is accepted;
// packet words and transfer halfwords follow decode; no-result items pass decode back to idle.
// Throughput: one item at a time; a transfer word gives one response per transferred
// halfword, a completed packet one response per emitted word (up to 12).
// Reset: synchronous active high; clears mode, draw state and counters; packet store unreset.
`timescale 1ns / 1ps
module gpu_command_packet_framer_core #(
   parameter int MAX_PACKET_WORDS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_wdata,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,  // word
   input  logic req_tuser,         // command (0 write, 1 read)
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [18:0] vram_address, [34:19] vram_data, [35] skip_if_masked, [36] read_half_high,
   // [44:37] packet_opcode, [48:45] packet_index, [80:49] payload
   output logic [87:0] rsp_tdata,
   output logic [2:0] rsp_tuser,   // kind
   output logic rsp_tlast
);
   // 24-bit colour mode register
   logic cd24_ff;
   gcpf_pkg::dp_cmd_type cmd;
   gcpf_pkg::dp_status_type sts;
   logic [2:0] kind;
   logic [18:0] addr;
   logic [15:0] vdata;
   logic skip, hhi;
   logic [7:0] pop;
   logic [3:0] pidx;
   logic [31:0] pay;

   always_ff @(posedge clock) begin
      if (reset) cd24_ff <= 1'b0;
      else if (csr_we) cd24_ff <= csr_wdata;
   end

   gcpf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_last(rsp_tlast),
      .cmd(cmd), .sts(sts)
   );

   gcpf_dp #(.MAX_PACKET_WORDS(MAX_PACKET_WORDS)) u_dp (
      .clock(clock), .reset(reset), .color_depth_24(cd24_ff),
      .in_command(req_tuser), .in_word(req_tdata),
      .cmd(cmd), .sts(sts),
      .out_kind(kind), .out_vram_address(addr), .out_vram_data(vdata),
      .out_skip_if_masked(skip), .out_read_half_high(hhi),
      .out_packet_opcode(pop), .out_packet_index(pidx), .out_payload(pay)
   );

   assign rsp_tdata = {7'd0, pay, pidx, pop, hhi, skip, vdata, addr};
   assign rsp_tuser = kind;
endmodule
